[sv/bvm_pkg.sv]
// ============================================================================
// bvm_pkg
// Shared types, constants and sequencer codes of the bouncing vertex motion
// unit.
// ============================================================================
package bvm_pkg;

    // Geometry of the vertex store
    localparam int NUM_POLYGONS = 2;
    localparam int MAX_VERTICES = 6;
    localparam int COORD_BITS   = 12;
    localparam int NUM_SLOTS    = NUM_POLYGONS * MAX_VERTICES;

    localparam int POLY_W  = (NUM_POLYGONS > 1) ? $clog2(NUM_POLYGONS) : 1;
    localparam int VERT_W  = $clog2(MAX_VERTICES + 1);
    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int SIZE_W  = COORD_BITS + 1;
    localparam int VEL_W   = 4;
    localparam int CFG_W   = 13;
    localparam int WORD_W  = 32;
    localparam int ITER_W  = $clog2(WORD_W);
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;

    // Seed mixing
    localparam logic [WORD_W-1:0] MIX_MUL       = 32'd2654435761;
    localparam logic [WORD_W-1:0] MIX_ADD       = 32'h9E3779B9;
    localparam logic [WORD_W-1:0] SEED_FALLBACK = 32'h12345678;

    // Generator shifts
    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    // Draw ranges
    localparam int VCOUNT_LO   = 3;
    localparam int VCOUNT_SPAN = MAX_VERTICES - VCOUNT_LO + 1;
    localparam int MAG_LO      = 2;
    localparam int MAG_HI      = 7;
    localparam int MAG_SPAN    = MAG_HI - MAG_LO + 1;

    // Reset values of the area registers
    localparam logic [CFG_W-1:0] AREA_W_RESET = 13'd1280;
    localparam logic [CFG_W-1:0] AREA_H_RESET = 13'd720;
    localparam logic [CFG_W-1:0] AREA_TOP     = CFG_W'(1 << COORD_BITS);

    // Register indexes
    typedef enum logic {
        REG_AREA_WIDTH  = 1'b0,
        REG_AREA_HEIGHT = 1'b1
    } t_reg_idx;

    // Input action codes
    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_INIT = 1'b1
    } t_action;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_FIX,
        ST_DRAW,
        ST_DIV,
        ST_APPLY,
        ST_MOVE,
        ST_EMIT
    } t_state;

    // Which random draw the sequencer is on
    typedef enum logic [2:0] {
        DR_COUNT,
        DR_X,
        DR_Y,
        DR_MAGX,
        DR_SGNX,
        DR_MAGY,
        DR_SGNY
    } t_draw;

    // One axis of one vertex
    typedef struct packed {
        logic [COORD_BITS-1:0]   pos;
        logic signed [VEL_W-1:0] vel;
    } t_axis;

endpackage

[sv/bouncing_vertex_motion_unit.sv]
// ============================================================================
// bouncing_vertex_motion_unit
// Two polygons of bouncing vertices placed by a xorshift32 generator and
// advanced one tick at a time.
// ============================================================================
// An init item (tuser = 1) mixes tdata into the generator seed and places
// 3 to 6 vertices per polygon; a tick item (tuser = 0) moves every vertex by
// its velocity and bounces it off the area edges. Either item returns one
// result per vertex, polygon by polygon, with tlast on the final one; a tick
// before any init returns nothing. The block takes one item at a time. Every
// range draw runs through one shared restoring remainder unit that retires
// one dividend bit per cycle; a sign draw skips the unit and takes the low bit
// of the generator word, and a one-value range gives zero. A tick moves every
// vertex, polygon by polygon, then walks them again to emit. Results sit in an
// output register, so the next item is taken while the last result waits.
module bouncing_vertex_motion_unit
    import bvm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    // input items
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,   // [31:0] time_ms
    input  logic              s_axis_tuser,   // [0] action
    // result items
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [0] polygon_index, [3:1] vertex_index, [6:4] vertex_total,
    // [18:7] x_pos, [30:19] y_pos, [31] zero
    output logic [OUT_W-1:0]  m_axis_tdata,
    output logic              m_axis_tlast
);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] x;
        x = w;
        x = x ^ (x << SHIFT_A);
        x = x ^ (x >> SHIFT_B);
        x = x ^ (x << SHIFT_C);
        return x;
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] s;
        if (v == '0) begin
            s = CFG_W'(1);
        end else if (v > AREA_TOP) begin
            s = AREA_TOP;
        end else begin
            s = v;
        end
        return SIZE_W'(s);
    endfunction

    function automatic t_axis move_axis(input t_axis a, input logic [SIZE_W-1:0] size);
        logic signed [COORD_BITS+1:0] sum;
        t_axis                        r;
        sum = $signed({2'b00, a.pos})
            + $signed({{(COORD_BITS + 2 - VEL_W){a.vel[VEL_W-1]}}, a.vel});
        r = a;
        if (sum[COORD_BITS+1]) begin
            r.pos = '0;
            r.vel = -a.vel;
        end else if (sum[COORD_BITS:0] >= size) begin
            r.pos = COORD_BITS'(size - SIZE_W'(1));
            r.vel = -a.vel;
        end else begin
            r.pos = sum[COORD_BITS-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                   r_state, n_state;
    t_draw                    r_draw;
    logic [CFG_W-1:0]         r_area_w, r_area_h;
    logic [WORD_W-1:0]        r_time;
    logic [WORD_W-1:0]        r_rng;
    logic [WORD_W-1:0]        r_shift;
    logic [SIZE_W-1:0]        r_rem;
    logic [SIZE_W-1:0]        r_divisor;
    logic [ITER_W-1:0]        r_iter;
    logic [VEL_W-1:0]         r_mag;
    logic [POLY_W-1:0]        r_poly;
    logic [VERT_W-1:0]        r_vert;
    logic [VERT_W-1:0]        r_vcnt [NUM_POLYGONS];
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_data;
    logic                     r_out_last;

    logic [COORD_BITS-1:0]    r_px [NUM_SLOTS];
    logic [COORD_BITS-1:0]    r_py [NUM_SLOTS];
    logic signed [VEL_W-1:0]  r_vx [NUM_SLOTS];
    logic signed [VEL_W-1:0]  r_vy [NUM_SLOTS];

    // ------------------------------------------------------------------
    // Derived signals
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0]  w_eff_w, w_eff_h;
    logic [WORD_W-1:0]  w_nxt_word;
    logic               w_accept;
    logic               w_slot_free;
    logic               w_load_out;
    logic [SLOT_W-1:0]  w_slot;
    logic [VERT_W-1:0]  w_cur_cnt;
    logic               w_in_poly;
    logic               w_last_poly;
    logic               w_vert_end;
    logic               w_later_empty;
    logic               w_skip;
    logic               w_sign_draw;
    logic [SIZE_W-1:0]  w_divisor;
    logic [SIZE_W:0]    w_trial;
    logic [SIZE_W-1:0]  w_rem_next;
    t_axis              w_ax, w_ay;

    assign w_eff_w     = eff_size(r_area_w);
    assign w_eff_h     = eff_size(r_area_h);
    assign w_nxt_word  = xorshift(r_rng);
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_slot_free = !r_out_valid || m_axis_tready;
    assign w_slot      = SLOT_W'(r_poly * MAX_VERTICES) + SLOT_W'(r_vert);
    assign w_cur_cnt   = r_vcnt[r_poly];
    assign w_in_poly   = r_vert < w_cur_cnt;
    assign w_last_poly = r_poly == POLY_W'(NUM_POLYGONS - 1);
    assign w_vert_end  = r_vert == VERT_W'(w_cur_cnt - VERT_W'(1));
    assign w_sign_draw = (r_draw == DR_SGNX) || (r_draw == DR_SGNY);

    // True when no polygon after the current one has any vertex
    always_comb begin
        w_later_empty = 1'b1;
        for (int i = 0; i < NUM_POLYGONS; i++) begin
            if ((POLY_W'(i) > r_poly) && (r_vcnt[i] != '0)) begin
                w_later_empty = 1'b0;
            end
        end
    end

    // Pick the range of the current draw
    always_comb begin
        w_divisor = SIZE_W'(MAG_SPAN);
        w_skip    = 1'b0;
        unique case (r_draw)
            DR_COUNT: begin
                w_divisor = SIZE_W'(VCOUNT_SPAN);
                w_skip    = VCOUNT_SPAN == 1;
            end
            DR_X: begin
                w_divisor = w_eff_w;
                w_skip    = w_eff_w == SIZE_W'(1);
            end
            DR_Y: begin
                w_divisor = w_eff_h;
                w_skip    = w_eff_h == SIZE_W'(1);
            end
            DR_MAGX, DR_SGNX, DR_MAGY, DR_SGNY: begin
                w_divisor = SIZE_W'(MAG_SPAN);
                w_skip    = 1'b0;
            end
            default: begin
                w_divisor = SIZE_W'(MAG_SPAN);
                w_skip    = 1'b0;
            end
        endcase
    end

    // One restoring remainder step
    assign w_trial    = {r_rem, r_shift[WORD_W-1]};
    assign w_rem_next = (w_trial >= {1'b0, r_divisor})
                      ? SIZE_W'(w_trial - {1'b0, r_divisor})
                      : SIZE_W'(w_trial);

    // Bounce both axes of the current vertex
    assign w_ax = move_axis('{pos: r_px[w_slot], vel: r_vx[w_slot]}, w_eff_w);
    assign w_ay = move_axis('{pos: r_py[w_slot], vel: r_vy[w_slot]}, w_eff_h);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (t_action'(s_axis_tuser) == ACT_INIT) ? ST_SEED : ST_MOVE;
                end
            end
            ST_SEED: n_state = ST_FIX;
            ST_FIX:  n_state = ST_DRAW;
            ST_DRAW: begin
                if (w_skip || w_sign_draw) begin
                    n_state = ST_APPLY;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_iter == ITER_W'(WORD_W - 1)) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if ((r_draw == DR_SGNY) && w_vert_end && w_last_poly) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_DRAW;
                end
            end
            ST_MOVE: begin
                if (!w_in_poly && w_last_poly) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!w_in_poly && w_last_poly) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = r_state == ST_IDLE;
        w_load_out    = (r_state == ST_EMIT) && w_in_poly && w_slot_free;
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_draw      <= DR_COUNT;
            r_area_w    <= AREA_W_RESET;
            r_area_h    <= AREA_H_RESET;
            r_rng       <= '0;
            r_poly      <= '0;
            r_vert      <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_POLYGONS; i++) begin
                r_vcnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_addr))
                    REG_AREA_WIDTH:  r_area_w <= i_cfg_wdata;
                    REG_AREA_HEIGHT: r_area_h <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // Drop the result once taken, refill from the emit walk
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_poly <= '0;
                        r_vert <= '0;
                        r_draw <= DR_COUNT;
                    end
                end
                ST_SEED: begin
                    r_rng <= WORD_W'(r_time * MIX_MUL) + MIX_ADD;
                end
                ST_FIX: begin
                    if (r_rng == '0) begin
                        r_rng <= SEED_FALLBACK;
                    end
                end
                ST_DRAW: begin
                    r_iter <= '0;
                    if (!w_skip) begin
                        r_rng <= w_nxt_word;
                    end
                end
                ST_DIV: begin
                    r_iter <= r_iter + ITER_W'(1);
                end
                ST_APPLY: begin
                    unique case (r_draw)
                        DR_COUNT: begin
                            r_vcnt[r_poly] <= VERT_W'(VCOUNT_LO) + VERT_W'(r_rem);
                            r_vert         <= '0;
                            r_draw         <= DR_X;
                        end
                        DR_X:    r_draw <= DR_Y;
                        DR_Y:    r_draw <= DR_MAGX;
                        DR_MAGX: r_draw <= DR_SGNX;
                        DR_SGNX: r_draw <= DR_MAGY;
                        DR_MAGY: r_draw <= DR_SGNY;
                        DR_SGNY: begin
                            if (!w_vert_end) begin
                                r_vert <= r_vert + VERT_W'(1);
                                r_draw <= DR_X;
                            end else if (!w_last_poly) begin
                                r_poly <= r_poly + POLY_W'(1);
                                r_draw <= DR_COUNT;
                            end else begin
                                r_poly <= '0;
                                r_vert <= '0;
                                r_draw <= DR_COUNT;
                            end
                        end
                        default: r_draw <= DR_COUNT;
                    endcase
                end
                ST_MOVE, ST_EMIT: begin
                    // Walk the vertices; emit waits for a free output slot
                    if (w_in_poly) begin
                        if ((r_state == ST_MOVE) || w_slot_free) begin
                            r_vert <= r_vert + VERT_W'(1);
                        end
                    end else if (!w_last_poly) begin
                        r_poly <= r_poly + POLY_W'(1);
                        r_vert <= '0;
                    end else begin
                        r_poly <= '0;
                        r_vert <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: remainder unit, magnitude, output slot
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time <= s_axis_tdata;
        end

        // Load the remainder unit, or force zero on a one-value range
        if (r_state == ST_DRAW) begin
            r_rem     <= '0;
            r_shift   <= w_nxt_word;
            r_divisor <= w_divisor;
        end else if (r_state == ST_DIV) begin
            r_rem   <= w_rem_next;
            r_shift <= r_shift << 1;
        end

        // Hold the magnitude until its sign is drawn
        if ((r_state == ST_APPLY) && ((r_draw == DR_MAGX) || (r_draw == DR_MAGY))) begin
            r_mag <= VEL_W'(MAG_LO) + VEL_W'(r_rem);
        end

        if (w_load_out) begin
            r_out_data <= OUT_W'({r_py[w_slot], r_px[w_slot], w_cur_cnt, r_vert, r_poly});
            r_out_last <= w_vert_end && w_later_empty;
        end
    end

    // ------------------------------------------------------------------
    // Vertex store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (r_state == ST_APPLY) begin
            unique case (r_draw)
                DR_X:    r_px[w_slot] <= COORD_BITS'(r_rem);
                DR_Y:    r_py[w_slot] <= COORD_BITS'(r_rem);
                DR_SGNX: r_vx[w_slot] <= r_rng[0] ? $signed(r_mag) : -$signed(r_mag);
                DR_SGNY: r_vy[w_slot] <= r_rng[0] ? $signed(r_mag) : -$signed(r_mag);
                DR_COUNT, DR_MAGX, DR_MAGY: ;
                default: ;
            endcase
        end else if ((r_state == ST_MOVE) && w_in_poly) begin
            r_px[w_slot] <= w_ax.pos;
            r_vx[w_slot] <= w_ax.vel;
            r_py[w_slot] <= w_ay.pos;
            r_vy[w_slot] <= w_ay.vel;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_divisor))
        else $error("remainder reached the divisor");

    a_rng_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAW) |-> (r_rng != '0))
        else $error("generator word is zero during a draw");

    a_init_seeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tuser) |=> (r_state == ST_SEED))
        else $error("init item did not start seeding");

    for (genvar g = 0; g < NUM_POLYGONS; g++) begin : g_cnt_chk
        a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_vcnt[g] == '0) || ((r_vcnt[g] >= VERT_W'(VCOUNT_LO))
                               && (r_vcnt[g] <= VERT_W'(MAX_VERTICES))))
            else $error("vertex count out of range");
    end

endmodule

[dv/bouncing_vertex_motion_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// bouncing_vertex_motion_unit_tb
// Self-checking bench for the bouncing vertex motion unit. A directed table
// covers tick before init, seed extremes, the zero-seed fallback, one-pixel,
// oversized and shrunk areas. Random phases of init and tick items follow,
// under changing area sizes and idle patterns, with two long output
// hold-offs. Every result is checked against an in-bench motion predictor.
// ============================================================================
module bouncing_vertex_motion_unit_tb;
    import bvm_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 9;
    // An init has no handshake while it runs and the output hold-off blocks
    // every result, so this leaves several times the longest quiet stretch.
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int SETTLE_CYCLES   = 80;
    localparam int HOLD_CYCLES     = 2500;
    localparam int RANDOM_PHASES   = 10;
    localparam int PHASE_ITEMS     = 41;
    localparam int MAX_REPORTS     = 30;

    typedef enum logic [1:0] {
        OUT_PREDICTED,
        OUT_SILENT,
        OUT_AT_ORIGIN
    } t_outcome;

    typedef struct packed {
        logic                  last;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] x;
        logic [2:0]            total;
        logic [2:0]            vert;
        logic                  poly;
    } t_vertex_result;

    typedef struct {
        bit                 is_write;
        t_reg_idx           reg_idx;
        logic [CFG_W-1:0]   value;
        t_action            act;
        logic [IN_W-1:0]    stamp;
        t_outcome           outcome;
    } t_stim_row;

    // DUT connections
    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_addr = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;    // [31:0] time_ms
    logic              s_axis_tuser = 1'b0;  // [0] action
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [0] polygon_index, [3:1] vertex_index, [6:4] vertex_total,
    // [18:7] x_pos, [30:19] y_pos, [31] zero
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tlast;

    // Predictor state
    logic [CFG_W-1:0]        cfg_width = AREA_W_RESET;
    logic [CFG_W-1:0]        cfg_height = AREA_H_RESET;
    logic [WORD_W-1:0]       shift_word = '0;
    logic [2:0]              poly_vertices [NUM_POLYGONS] = '{default: '0};
    logic [COORD_BITS-1:0]   px [NUM_SLOTS] = '{default: '0};
    logic [COORD_BITS-1:0]   py [NUM_SLOTS] = '{default: '0};
    logic signed [VEL_W-1:0] sx [NUM_SLOTS] = '{default: '0};
    logic signed [VEL_W-1:0] sy [NUM_SLOTS] = '{default: '0};

    t_vertex_result pending_vertices [$];
    t_stim_row      directed_rows [$];

    int mismatch_count = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_request = 1'b0;
    int hold_left = 0;

    bouncing_vertex_motion_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Clamp a register value to the usable area extent
    function automatic int usable_extent(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > AREA_TOP)
            return int'(AREA_TOP);
        return int'(v);
    endfunction

    // Advance the generator one step and return the new word
    function automatic logic [WORD_W-1:0] xorshift_next();
        logic [WORD_W-1:0] w;
        w = shift_word;
        w = w ^ (w << SHIFT_A);
        w = w ^ (w >> SHIFT_B);
        w = w ^ (w << SHIFT_C);
        shift_word = w;
        return w;
    endfunction

    // Uniform draw in [lo,hi]; an empty or one-value span takes no word
    function automatic int draw_between(input int lo, input int hi);
        logic [WORD_W-1:0] span;
        if (hi <= lo)
            return lo;
        span = WORD_W'(hi - lo + 1);
        return lo + int'(xorshift_next() % span);
    endfunction

    // Odd word means a positive velocity
    function automatic bit coin_flip();
        logic [WORD_W-1:0] w;
        w = xorshift_next();
        return w[0];
    endfunction

    // Move one axis and bounce off either edge
    task automatic bounce_step(inout logic [COORD_BITS-1:0] pos,
                               inout logic signed [VEL_W-1:0] vel,
                               input int extent);
        int nxt;
        begin
            nxt = int'(pos) + int'(vel);
            if (nxt < 0) begin
                pos = '0;
                vel = -vel;
            end else if (nxt >= extent) begin
                pos = COORD_BITS'(extent - 1);
                vel = -vel;
            end else begin
                pos = COORD_BITS'(nxt);
            end
        end
    endtask

    // Update the vertex store for one item and queue the vertex results
    task automatic advance_polygons(input t_action act, input logic [IN_W-1:0] stamp,
                                    input t_outcome outcome);
        int w;
        int h;
        int slot;
        int mag;
        int emitted;
        int total;
        t_vertex_result r;
        begin
            w = usable_extent(cfg_width);
            h = usable_extent(cfg_height);
            if (act == ACT_INIT) begin
                shift_word = stamp * MIX_MUL + MIX_ADD;
                if (shift_word == '0)
                    shift_word = SEED_FALLBACK;
                for (int p = 0; p < NUM_POLYGONS; p++) begin
                    poly_vertices[p] = 3'(draw_between(VCOUNT_LO, MAX_VERTICES));
                    for (int v = 0; v < int'(poly_vertices[p]); v++) begin
                        slot = p * MAX_VERTICES + v;
                        px[slot] = COORD_BITS'(draw_between(0, w - 1));
                        py[slot] = COORD_BITS'(draw_between(0, h - 1));
                        mag = draw_between(MAG_LO, MAG_HI);
                        sx[slot] = VEL_W'(coin_flip() ? mag : -mag);
                        mag = draw_between(MAG_LO, MAG_HI);
                        sy[slot] = VEL_W'(coin_flip() ? mag : -mag);
                    end
                end
            end else begin
                for (int p = 0; p < NUM_POLYGONS; p++) begin
                    for (int v = 0; v < int'(poly_vertices[p]); v++) begin
                        slot = p * MAX_VERTICES + v;
                        bounce_step(px[slot], sx[slot], w);
                        bounce_step(py[slot], sy[slot], h);
                    end
                end
            end

            // Queue one result per vertex; typed rows override the position
            if (outcome != OUT_SILENT) begin
                total = 0;
                for (int p = 0; p < NUM_POLYGONS; p++)
                    total += int'(poly_vertices[p]);
                emitted = 0;
                for (int p = 0; p < NUM_POLYGONS; p++) begin
                    for (int v = 0; v < int'(poly_vertices[p]); v++) begin
                        slot = p * MAX_VERTICES + v;
                        r.poly  = 1'(p);
                        r.vert  = 3'(v);
                        r.total = poly_vertices[p];
                        r.x     = (outcome == OUT_AT_ORIGIN) ? '0 : px[slot];
                        r.y     = (outcome == OUT_AT_ORIGIN) ? '0 : py[slot];
                        r.last  = (emitted == total - 1);
                        pending_vertices.push_back(r);
                        emitted++;
                    end
                end
            end
        end
    endtask

    // Offer one item, hold it until taken, then predict its results
    task automatic drive_item(input t_action act, input logic [IN_W-1:0] stamp,
                              input t_outcome outcome);
        begin
            while ($urandom_range(99) < sender_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= act;
            s_axis_tdata  <= stamp;
            do @(posedge i_clk); while (!s_axis_tready);
            advance_polygons(act, stamp, outcome);
        end
    endtask

    // Drop valid, wait for every result, then let the block settle
    task automatic wait_drained();
        begin
            s_axis_tvalid <= 1'b0;
            while (pending_vertices.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= idx;
            i_cfg_wdata <= value;
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            if (idx == REG_AREA_WIDTH)
                cfg_width = value;
            else
                cfg_height = value;
        end
    endtask

    task automatic add_item(input t_action act, input logic [IN_W-1:0] stamp,
                            input t_outcome outcome);
        t_stim_row row;
        begin
            row.is_write = 1'b0;
            row.reg_idx  = REG_AREA_WIDTH;
            row.value    = '0;
            row.act      = act;
            row.stamp    = stamp;
            row.outcome  = outcome;
            directed_rows.push_back(row);
        end
    endtask

    task automatic add_write(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        t_stim_row row;
        begin
            row.is_write = 1'b1;
            row.reg_idx  = idx;
            row.value    = value;
            row.act      = ACT_TICK;
            row.stamp    = '0;
            row.outcome  = OUT_PREDICTED;
            directed_rows.push_back(row);
        end
    endtask

    // Area size for a random phase, weighted toward edges and small boxes
    function automatic logic [CFG_W-1:0] pick_area();
        case ($urandom_range(6))
            0:       return '0;
            1:       return CFG_W'($urandom_range(1, 8));
            2:       return CFG_W'($urandom_range(9, 300));
            3:       return CFG_W'($urandom_range(1, 4096));
            4:       return AREA_TOP;
            5:       return CFG_W'($urandom_range(4097, 8191));
            default: return CFG_W'($urandom_range(300, 2000));
        endcase
    endfunction

    // Check each result and drive the output back-pressure
    always @(posedge i_clk) begin : result_check
        t_vertex_result   want;
        logic [OUT_W-1:0] want_data;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_vertices.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, none pending, got tdata %h last %0d",
                             $time, m_axis_tdata, m_axis_tlast);
            end else begin
                want      = pending_vertices.pop_front();
                want_data = {1'b0, want.y, want.x, want.total, want.vert, want.poly};
                if (m_axis_tdata !== want_data || m_axis_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch, expected tdata %h last %0d, got tdata %h last %0d",
                                 $time, want_data, want.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end

        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    // Count cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** bouncing_vertex_motion_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [WORD_W-1:0] inverse;
        logic [WORD_W-1:0] zero_seed_time;
        t_stim_row row;
        t_action act;

        // Time value whose mixed seed is zero: solve with the odd inverse
        inverse = MIX_MUL;
        repeat (5) inverse = inverse * (32'd2 - MIX_MUL * inverse);
        zero_seed_time = (32'd0 - MIX_ADD) * inverse;

        // Directed table
        add_item(ACT_TICK, 32'hFFFF_FFFF, OUT_SILENT);   // no vertices yet
        add_item(ACT_TICK, 32'h0000_0000, OUT_SILENT);
        add_item(ACT_INIT, 32'h0000_0000, OUT_PREDICTED);
        add_item(ACT_TICK, $urandom(), OUT_PREDICTED);
        add_item(ACT_TICK, $urandom(), OUT_PREDICTED);
        add_item(ACT_INIT, 32'hFFFF_FFFF, OUT_PREDICTED);
        add_item(ACT_INIT, zero_seed_time, OUT_PREDICTED); // fallback seed
        add_item(ACT_TICK, 32'h0000_0000, OUT_PREDICTED);
        add_item(ACT_TICK, 32'hFFFF_FFFF, OUT_PREDICTED);
        // one-pixel area pins every vertex to the origin
        add_write(REG_AREA_WIDTH, 13'd1);
        add_write(REG_AREA_HEIGHT, 13'd1);
        add_item(ACT_INIT, 32'h5A5A_5A5A, OUT_AT_ORIGIN);
        add_item(ACT_TICK, 32'hA5A5_A5A5, OUT_AT_ORIGIN);
        // zero size counts as one pixel
        add_write(REG_AREA_WIDTH, 13'd0);
        add_write(REG_AREA_HEIGHT, 13'd0);
        add_item(ACT_INIT, 32'h1234_5678, OUT_AT_ORIGIN);
        add_item(ACT_TICK, 32'h0000_0000, OUT_AT_ORIGIN);
        add_write(REG_AREA_WIDTH, AREA_TOP);
        add_write(REG_AREA_HEIGHT, AREA_TOP);
        add_item(ACT_INIT, $urandom(), OUT_PREDICTED);
        add_item(ACT_TICK, 32'h0000_0000, OUT_PREDICTED);
        // oversized area saturates at the coordinate range
        add_write(REG_AREA_WIDTH, 13'h1FFF);
        add_write(REG_AREA_HEIGHT, AREA_TOP + 13'd1);
        add_item(ACT_INIT, $urandom(), OUT_PREDICTED);
        add_item(ACT_TICK, 32'h0000_0000, OUT_PREDICTED);
        // shrink without reseeding: out-of-area vertices clamp and reverse
        add_write(REG_AREA_WIDTH, 13'd2);
        add_write(REG_AREA_HEIGHT, 13'd3);
        add_item(ACT_TICK, 32'h0000_0000, OUT_PREDICTED);
        add_item(ACT_TICK, 32'h0000_0000, OUT_PREDICTED);
        add_write(REG_AREA_WIDTH, AREA_W_RESET);
        add_write(REG_AREA_HEIGHT, AREA_H_RESET);
        add_item(ACT_INIT, $urandom(), OUT_PREDICTED);
        add_item(ACT_TICK, 32'h0000_0000, OUT_PREDICTED);

        // Hold reset, then release it at a clock edge
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.is_write) begin
                wait_drained();
                write_reg(row.reg_idx, row.value);
            end else begin
                drive_item(row.act, row.stamp, row.outcome);
            end
        end

        // Random phases under changing areas and idle patterns
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            write_reg(REG_AREA_WIDTH, pick_area());
            write_reg(REG_AREA_HEIGHT, pick_area());
            case (phase % 5)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 86;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 86;
                end
                3: begin
                    sender_idle_pct    = 32;
                    receiver_stall_pct = 32;
                end
                default: begin
                    // long output hold-off while items keep coming
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                    hold_request       = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                act = ($urandom_range(99) < ((n == 0) ? 50 : 10)) ? ACT_INIT : ACT_TICK;
                drive_item(act, $urandom(), OUT_PREDICTED);
            end
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("** bouncing_vertex_motion_unit: PASSED **");
        else
            $display("** bouncing_vertex_motion_unit: FAILED **");
        $finish;
    end

endmodule

[bouncing_vertex_motion_unit.f]
sv/bvm_pkg.sv
sv/bouncing_vertex_motion_unit.sv
dv/bouncing_vertex_motion_unit_tb.sv
